/* rtl/core/text_console_char_writer_top_macros.svh */
// Assertion macros used by the console writer controller.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define TCCW_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define TCCW_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/core/tccw_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package tccw_pkg;

	localparam int CURSOR_W  = 11;
	localparam int ADDR_IN_W = 11;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 32;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [BYTE_W-1:0] CODE_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] CODE_NEWLINE   = 8'h0a;
	localparam logic [BYTE_W-1:0] CODE_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [BYTE_W-1:0] BLANK_ATTR     = 8'h07;

	typedef enum logic [1:0] {
		PTR_HOLD     = 2'd0,
		PTR_ZERO     = 2'd1,
		PTR_COLS     = 2'd2,
		PTR_LAST_ROW = 2'd3
	} ptr_op_t;

	typedef struct packed {
		logic    latch;
		logic    exec_put;
		logic    exec_read;
		logic    copy_step;
		logic    blank_step;
		ptr_op_t ptr_op;
		logic    cursor_clear;
		logic    cursor_scroll;
		logic    set_scrolled;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic kind_put;
		logic kind_read;
		logic kind_clear;
		logic need_scroll;
		logic ptr_last;
		logic out_busy;
	} dp_sts_t;

endpackage

/* rtl/core/tccw_dpath.sv */
// Datapath: item registers, cursor tracking, screen memory, sweep pointer, result register.
module tccw_dpath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tccw_pkg::dp_cmd_t                   cmd,
	output tccw_pkg::dp_sts_t                   sts,
	input  logic [tccw_pkg::KIND_W-1:0]         item_kind,
	input  logic [tccw_pkg::BYTE_W-1:0]         item_code,
	input  logic [tccw_pkg::BYTE_W-1:0]         item_attr,
	input  logic                                item_eom,
	input  logic [tccw_pkg::ADDR_IN_W-1:0]      item_addr,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tccw_pkg::CURSOR_W-1:0]       out_cursor,
	output logic                                out_scrolled,
	output logic [tccw_pkg::BYTE_W-1:0]         out_char,
	output logic [tccw_pkg::BYTE_W-1:0]         out_attr
);
	import tccw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int CW    = $clog2(CELLS + 1);
	localparam int NW    = CW + 1;
	localparam int AW    = $clog2(CELLS);
	localparam int COLW  = $clog2(COLUMNS);
	localparam int CELL_W = 2 * BYTE_W;

	localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
	localparam logic [CW-1:0]   COLS_C     = CW'(COLUMNS);
	localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
	localparam logic [AW-1:0]   PTR_END_C  = AW'(CELLS - 1);
	localparam logic [COLW-1:0] COL_MAX_C  = COLW'(COLUMNS - 1);
	localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

	logic [KIND_W-1:0]  kind_q;
	logic [BYTE_W-1:0]  code_q;
	logic [BYTE_W-1:0]  attr_q;
	logic               eom_q;
	logic [AW-1:0]      addr_q;
	logic               read_ok_q;
	logic               scrolled_q;

	logic [CW-1:0]      cursor_q, cursor_d;
	logic [CW-1:0]      row_base_q, row_base_d;
	logic [COLW-1:0]    col_q, col_d;
	logic [NW-1:0]      next_row;

	logic [AW-1:0]      ptr_q;
	logic               copy_s1;
	logic [AW-1:0]      dst_s1;

	logic [CELL_W-1:0]  mem [CELLS];
	logic [CELL_W-1:0]  rdata_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [CELL_W-1:0]  wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;

	logic               is_newline, is_backspace, is_printable;
	logic               out_valid_q;
	logic [CURSOR_W-1:0] out_cursor_q;
	logic               out_scrolled_q;
	logic [BYTE_W-1:0]  out_char_q, out_attr_q;

	// Latch the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q    <= item_kind;
			code_q    <= item_code;
			attr_q    <= item_attr;
			eom_q     <= item_eom;
			addr_q    <= AW'(item_addr);
			read_ok_q <= (item_kind == KIND_READ) && (32'(item_addr) < 32'(CELLS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scrolled_q <= 1'b0;
		end else if (cmd.latch) begin
			scrolled_q <= 1'b0;
		end else if (cmd.set_scrolled) begin
			scrolled_q <= 1'b1;
		end
	end

	assign is_newline   = (code_q == CODE_NEWLINE);
	assign is_backspace = (code_q == CODE_BACKSPACE);
	assign is_printable = !is_newline && !is_backspace && (code_q != CODE_NUL);
	assign next_row     = {1'b0, row_base_q} + NW'(COLUMNS);

	// Cursor is kept as row start plus column, so newline needs no divide.
	always_comb begin
		cursor_d   = cursor_q;
		row_base_d = row_base_q;
		col_d      = col_q;
		if (cmd.cursor_clear) begin
			cursor_d   = '0;
			row_base_d = '0;
			col_d      = '0;
		end else if (cmd.cursor_scroll) begin
			cursor_d   = LAST_ROW_C;
			row_base_d = LAST_ROW_C;
			col_d      = '0;
		end else if (cmd.exec_put) begin
			if (is_newline) begin
				col_d = '0;
				if (next_row >= NW'(CELLS)) begin
					cursor_d   = CELLS_C;
					row_base_d = CELLS_C;
				end else begin
					cursor_d   = CW'(next_row);
					row_base_d = CW'(next_row);
				end
			end else if (is_backspace) begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - 1'b1;
					if (col_q == '0) begin
						col_d      = COL_MAX_C;
						row_base_d = row_base_q - COLS_C;
					end else begin
						col_d = col_q - 1'b1;
					end
				end
			end else if (is_printable && (cursor_q < CELLS_C)) begin
				cursor_d = cursor_q + 1'b1;
				if (col_q == COL_MAX_C) begin
					col_d      = '0;
					row_base_d = row_base_q + COLS_C;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			row_base_q <= '0;
			col_q      <= '0;
		end else begin
			cursor_q   <= cursor_d;
			row_base_q <= row_base_d;
			col_q      <= col_d;
		end
	end

	// Sweep pointer for clear, wipe and scroll passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			copy_s1 <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_step;
			case (cmd.ptr_op)
				PTR_ZERO:     ptr_q <= '0;
				PTR_COLS:     ptr_q <= AW'(COLUMNS);
				PTR_LAST_ROW: ptr_q <= AW'(CELLS - COLUMNS);
				default: begin
					if (cmd.copy_step || cmd.blank_step) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_step) begin
			dst_s1 <= ptr_q - AW'(COLUMNS);
		end
	end

	// Single write port: pending copy, blank sweep, or the put item.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = BLANK_CELL;
		if (copy_s1) begin
			wr_en   = 1'b1;
			wr_addr = dst_s1;
			wr_data = rdata_q;
		end else if (cmd.blank_step) begin
			wr_en = 1'b1;
		end else if (cmd.exec_put) begin
			if (is_backspace) begin
				wr_en   = (cursor_q != '0);
				wr_addr = AW'(cursor_q - 1'b1);
			end else if (is_printable) begin
				wr_en   = (cursor_q < CELLS_C);
				wr_addr = AW'(cursor_q);
				wr_data = {attr_q, code_q};
			end
		end
	end

	assign rd_en   = cmd.copy_step || cmd.exec_read;
	assign rd_addr = cmd.copy_step ? ptr_q : addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Result register: hold until the downstream transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cursor_q   <= CURSOR_W'(cursor_q);
			out_scrolled_q <= scrolled_q;
			out_char_q     <= read_ok_q ? rdata_q[BYTE_W-1:0] : '0;
			out_attr_q     <= read_ok_q ? rdata_q[CELL_W-1:BYTE_W] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_cursor   = out_cursor_q;
	assign out_scrolled = out_scrolled_q;
	assign out_char     = out_char_q;
	assign out_attr     = out_attr_q;

	assign sts.kind_put    = (kind_q == KIND_PUT);
	assign sts.kind_read   = (kind_q == KIND_READ);
	assign sts.kind_clear  = (kind_q == KIND_CLEAR);
	assign sts.need_scroll = (kind_q == KIND_PUT) && eom_q && (cursor_q >= CELLS_C);
	assign sts.ptr_last    = (ptr_q == PTR_END_C);
	assign sts.out_busy    = out_valid_q && !out_ready;

endmodule

/* rtl/core/tccw_ctrl.sv */
// Controller: sequences item execution, screen sweeps and result hand-off.
module tccw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tccw_pkg::dp_sts_t sts,
	output tccw_pkg::dp_cmd_t cmd
);
	import tccw_pkg::*;

	typedef enum logic [6:0] {
		ST_WIPE  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_DONE  = 7'b0001000,
		ST_COPY  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_BLANK = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_WIPE: begin
				cmd.blank_step = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				if (sts.kind_put) begin
					cmd.exec_put = 1'b1;
				end else if (sts.kind_read) begin
					cmd.exec_read = 1'b1;
				end else if (sts.kind_clear) begin
					cmd.cursor_clear = 1'b1;
					cmd.ptr_op       = PTR_ZERO;
					state_d          = ST_BLANK;
				end
			end
			ST_DONE: begin
				if (sts.need_scroll) begin
					cmd.ptr_op       = PTR_COLS;
					cmd.set_scrolled = 1'b1;
					state_d          = ST_COPY;
				end else if (!sts.out_busy) begin
					// post the result and take the next item in the same cycle
					cmd.load_out = 1'b1;
					in_ready     = 1'b1;
					cmd.latch    = in_valid;
					state_d      = in_valid ? ST_EXEC : ST_IDLE;
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last copy write lands here; start blanking the bottom row next
				cmd.ptr_op        = PTR_LAST_ROW;
				cmd.cursor_scroll = 1'b1;
				state_d           = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.blank_step = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_DONE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

`include "text_console_char_writer_top_macros.svh"

	`TCCW_ASSERT_SAME(a_ready_state, in_ready, (state_q == ST_IDLE || state_q == ST_DONE), "ready outside idle or done")
	`TCCW_ASSERT_NEXT(a_accept_exec, (in_valid && in_ready), (state_q == ST_EXEC), "accepted item not executed")
	`TCCW_ASSERT_SAME(a_load_free, cmd.load_out, !sts.out_busy, "result loaded over a pending result")
	`TCCW_ASSERT_NEXT(a_copy_drain, (state_q == ST_COPY && sts.ptr_last), (state_q == ST_DRAIN), "scroll copy did not drain")

endmodule

/* rtl/core/text_console_char_writer_top.sv */
// Top level of the text console writer: stream ports, controller and datapath.
// Text console writer: a ROWS x COLUMNS screen of character/attribute cells and a cursor.
// Each input transfer puts a character (newline, backspace, printable, or zero as terminator),
// clears the screen, or reads one cell, and yields exactly one result transfer. Put, read and
// unused kinds pass through the controller in order: execute, then post the result, once the
// result register is free, while taking the next item; the registered read of the screen memory
// and the cursor update that the end-of-message check looks at are why the result is posted in
// a state of its own. Clear walks the whole memory one cell a cycle. An end-of-message put that
// leaves the cursor at the end scrolls by copying one cell a cycle and blanking the bottom row.
// After reset a clearing pass blanks the screen (character 0x20, attribute 0x07) before the
// first item is taken. The result register lets the next item be accepted while a finished
// result still waits to be taken.
module text_console_char_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// char_code[7:0], attribute[15:8], cell_address[26:16], zero[31:27]
	input  logic [tccw_pkg::S_DATA_W-1:0]   s_tdata,
	// kind[1:0]
	input  logic [tccw_pkg::KIND_W-1:0]     s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cursor[10:0], cell_char[18:11], cell_attr[26:19], zero[31:27]
	output logic [tccw_pkg::M_DATA_W-1:0]   m_tdata,
	// scrolled[0]
	output logic                            m_tuser
);
	import tccw_pkg::*;

	localparam int M_USED_W = CURSOR_W + 2 * BYTE_W;

	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic [CURSOR_W-1:0]    out_cursor;
	logic [BYTE_W-1:0]      out_char;
	logic [BYTE_W-1:0]      out_attr;

	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tccw_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_kind    (s_tuser),
		.item_code    (s_tdata[BYTE_W-1:0]),
		.item_attr    (s_tdata[2*BYTE_W-1:BYTE_W]),
		.item_eom     (s_tlast),
		.item_addr    (s_tdata[2*BYTE_W+ADDR_IN_W-1:2*BYTE_W]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_cursor   (out_cursor),
		.out_scrolled (m_tuser),
		.out_char     (out_char),
		.out_attr     (out_attr)
	);

	assign m_tdata = {{(M_DATA_W - M_USED_W){1'b0}}, out_attr, out_char, out_cursor};

endmodule

/* verif/tb_top.sv */
// Testbench for the text console writer: stream stimulus, screen predictor and result checks.
`timescale 1ns / 100ps

module tb_top;
	import tccw_pkg::*;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	// Clear and scroll walk the whole screen; allow two of them back to back.
	localparam int DRAIN_CYCLES = 2 * (CELL_COUNT + 2) + 100;
	localparam int LONG_HOLD    = 3000;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor;
		logic                scrolled;
		logic [BYTE_W-1:0]   cell_char;
		logic [BYTE_W-1:0]   cell_attr;
	} console_result_t;

	class console_scoreboard;
		logic [BYTE_W-1:0] scr_char [CELL_COUNT];
		logic [BYTE_W-1:0] scr_attr [CELL_COUNT];
		int                cur;
		console_result_t   expected_q[$];
		int                mismatches;

		function new();
			blank_cells(0, CELL_COUNT);
			cur = 0;
			mismatches = 0;
		endfunction

		function void blank_cells(int from, int to);
			for (int i = from; i < to && i < CELL_COUNT; i++) begin
				scr_char[i] = BLANK_CHAR;
				scr_attr[i] = BLANK_ATTR;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted input transfer to the screen and queue its result.
		function void note_input(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] code,
				logic [BYTE_W-1:0] attr, logic eom, logic [ADDR_IN_W-1:0] addr);
			int              next_row;
			console_result_t res;
			res = '0;
			case (kind)
				KIND_PUT: begin
					if (code == CODE_NEWLINE) begin
						next_row = (cur / COLUMNS + 1) * COLUMNS;
						cur = (next_row > CELL_COUNT) ? CELL_COUNT : next_row;
					end else if (code == CODE_BACKSPACE) begin
						if (cur > 0) begin
							cur--;
							blank_cells(cur, cur + 1);
						end
					end else if (code != CODE_NUL) begin
						// drop the character once the cursor is past the end
						if (cur < CELL_COUNT) begin
							scr_char[cur] = code;
							scr_attr[cur] = attr;
							cur++;
						end
					end
					if (eom && cur >= CELL_COUNT) begin
						for (int i = COLUMNS; i < CELL_COUNT; i++) begin
							scr_char[i - COLUMNS] = scr_char[i];
							scr_attr[i - COLUMNS] = scr_attr[i];
						end
						blank_cells(CELL_COUNT - COLUMNS, CELL_COUNT);
						cur = CELL_COUNT - COLUMNS;
						res.scrolled = 1'b1;
					end
				end
				KIND_CLEAR: begin
					blank_cells(0, CELL_COUNT);
					cur = 0;
				end
				KIND_READ: begin
					if (addr < CELL_COUNT) begin
						res.cell_char = scr_char[addr];
						res.cell_attr = scr_attr[addr];
					end
				end
				default: ;
			endcase
			res.cursor = cur[CURSOR_W-1:0];
			expected_q.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 200)
				$display("ERROR @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(console_result_t got);
			console_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing queued: cursor %0d", got.cursor));
				return;
			end
			want = expected_q.pop_front();
			if (got.cursor !== want.cursor)
				report_mismatch($sformatf("cursor %0d, want %0d", got.cursor, want.cursor));
			if (got.scrolled !== want.scrolled)
				report_mismatch($sformatf("scrolled %0b, want %0b", got.scrolled, want.scrolled));
			if (got.cell_char !== want.cell_char)
				report_mismatch($sformatf("cell_char %02h, want %02h",
					got.cell_char, want.cell_char));
			if (got.cell_attr !== want.cell_attr)
				report_mismatch($sformatf("cell_attr %02h, want %02h",
					got.cell_attr, want.cell_attr));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tuser;

	console_scoreboard sb;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_request;
	int items_sent;

	text_console_char_writer_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end

	// Offer one item and hold it until the transfer completes.
	task automatic send_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] code,
			logic [BYTE_W-1:0] attr, logic eom, logic [ADDR_IN_W-1:0] addr);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, addr, attr, code};
		s_tuser  <= kind;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(kind, code, attr, eom, addr);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Between phases: drop valid and let all results come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (8) @(posedge clk);
	endtask

	task automatic run_directed();
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd0);
		send_item(KIND_READ, 8'hff, 8'hff, 1'b1, 11'd1999);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2000);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2047);
		send_item(KIND_PUT, 8'h41, 8'hff, 1'b0, 11'd2047);
		send_item(KIND_PUT, 8'hff, 8'h00, 1'b0, 11'd0);
		send_item(KIND_PUT, 8'h01, 8'h5a, 1'b0, 11'd1234);
		send_item(KIND_PUT, CODE_BACKSPACE, 8'hff, 1'b0, 11'd0);
		send_item(KIND_PUT, CODE_NUL, 8'h33, 1'b1, 11'd0);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd0);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2);
		send_item(KIND_PUT, CODE_NEWLINE, 8'h00, 1'b1, 11'd0);
		send_item(KIND_PUT, 8'h7e, 8'h80, 1'b1, 11'd0);
		send_item(KIND_UNUSED, 8'hff, 8'hff, 1'b1, 11'd2047);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd80);
		send_item(KIND_CLEAR, 8'hff, 8'hff, 1'b1, 11'd2047);
		send_item(KIND_PUT, CODE_BACKSPACE, 8'h00, 1'b0, 11'd0);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd0);
		send_item(KIND_READ, 8'h00, 8'h00, 1'b0, 11'd80);
		send_item(KIND_PUT, CODE_NUL, 8'h00, 1'b0, 11'd0);
	endtask

	function automatic logic [BYTE_W-1:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return CODE_NEWLINE;
		else if (r < 35)
			return CODE_BACKSPACE;
		else if (r < 40)
			return CODE_NUL;
		else
			return BYTE_W'($urandom_range(1, 255));
	endfunction

	// Mostly messages ending in an end-of-message mark, with reads, noise and rare clears.
	task automatic run_random(int n_items);
		int target;
		int r;
		int len;
		logic eom;
		target = items_sent + n_items;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++) begin
					if (i == len - 1)
						eom = ($urandom_range(9) != 0);
					else
						eom = ($urandom_range(19) == 0);
					send_item(KIND_PUT, pick_code(), BYTE_W'($urandom),
						eom, ADDR_IN_W'($urandom));
				end
			end else if (r < 90) begin
				send_item(KIND_READ, BYTE_W'($urandom), BYTE_W'($urandom),
					1'($urandom), ADDR_IN_W'($urandom_range(0, 2047)));
			end else if (r < 96) begin
				send_item(KIND_PUT, BYTE_W'($urandom), BYTE_W'($urandom),
					1'($urandom), ADDR_IN_W'($urandom));
			end else if (r < 98) begin
				send_item(KIND_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom),
					1'($urandom), ADDR_IN_W'($urandom));
			end else begin
				send_item(KIND_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom),
					1'($urandom), ADDR_IN_W'($urandom));
			end
		end
	endtask

	// Result side: check each transfer, then choose ready for the next edge.
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge clk);
		forever begin
			if (m_tvalid && m_tready)
				sb.check_result(console_result_t'({m_tdata[10:0], m_tuser,
					m_tdata[18:11], m_tdata[26:19]}));
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
			@(posedge clk);
		end
	end

	initial begin
		sb = new();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_request   = 0;
		items_sent     = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= KIND_PUT;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();

		// no idling, with one long stall on the result side
		hold_request = LONG_HOLD;
		run_random(160);
		settle();

		src_idle_pct = 78;
		run_random(160);
		settle();

		src_idle_pct   = 0;
		sink_stall_pct = 78;
		run_random(80);
		// pause the input until every result is back
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		run_random(80);
		settle();

		src_idle_pct   = 38;
		sink_stall_pct = 38;
		run_random(160);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch("expected results left over");
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
